// File: rtl/lru_page_replacement_macros.svh
// Assertion macros used by the LRU page replacement controller.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("LRU check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("LRU check failed one cycle later");

`endif

// File: rtl/lru_pkg.sv
// Package with constants, types and helper functions for the LRU page replacement block.
`default_nettype none

package lru_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;
  localparam int FIDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int AGE_W     = FIDX_W;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int CFG_W     = 5;
  localparam int TOTAL_W   = 32;
  localparam int AGE_MAX   = FRAMES - 1;
  localparam int CFG_RESET = 16;

  typedef logic [FRAMES-1:0]    frame_vec_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [AGE_W-1:0]     age_t;
  typedef logic [FIDX_W-1:0]    fidx_t;
  typedef logic [CNT_W-1:0]     fcnt_t;
  typedef logic [TOTAL_W-1:0]   total_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
    logic cfg_write;
  } dp_cmd_t;

  function automatic fcnt_t active_count(input logic [CFG_W-1:0] v);
    fcnt_t n;
    if (v == '0) begin
      n = fcnt_t'(1);
    end else if (int'(v) > FRAMES) begin
      n = fcnt_t'(FRAMES);
    end else begin
      n = fcnt_t'(v);
    end
    return n;
  endfunction

  function automatic frame_vec_t active_mask(input fcnt_t n);
    frame_vec_t m;
    m = '0;
    for (int i = 0; i < FRAMES; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

  function automatic frame_vec_t lowest_set(input frame_vec_t v);
    return v & (~v + frame_vec_t'(1));
  endfunction

  function automatic fidx_t encode(input frame_vec_t onehot);
    fidx_t idx;
    idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (onehot[i]) begin
        idx = idx | fidx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lru_ctrl.sv
// Controller state machine that sequences capture, lookup and update of each request.
`default_nettype none

module lru_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            cfg_valid,
  output logic                 busy,
  output logic                 cfg_ready,
  output logic                 out_valid,
  output lru_pkg::dp_cmd_t     cmd
);
  import lru_pkg::*;

  `include "lru_page_replacement_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   accept;

  assign busy      = (state_r == S_LOOKUP);
  assign cfg_ready = (state_r == S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        state_nxt = accept ? S_LOOKUP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.capture   = accept;
    cmd.lookup    = (state_r == S_LOOKUP);
    cmd.update    = (state_r == S_UPDATE);
    cmd.cfg_write = cfg_valid && cfg_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_UPDATE);
    end
  end

  `LRU_ASSERT_NEXT(a_accept_to_lookup, start && !busy, state_r == S_LOOKUP)
  `LRU_ASSERT_NEXT(a_lookup_to_update, state_r == S_LOOKUP, state_r == S_UPDATE)
  `LRU_ASSERT_NEXT(a_update_strobes, state_r == S_UPDATE, out_valid)
  `LRU_ASSERT_SAME(a_strobe_not_idle_cfg, cfg_valid && cfg_ready, !cmd.capture || !start)

endmodule

`default_nettype wire

// File: rtl/lru_dp.sv
// Datapath with frame table, parallel tag compare, oldest-frame select and counters.
`default_nettype none

module lru_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lru_pkg::dp_cmd_t               cmd,
  input  wire logic [lru_pkg::PAGE_BITS-1:0]  page_in,
  input  wire logic [lru_pkg::CFG_W-1:0]      cfg_data,
  output logic                                hit,
  output logic [lru_pkg::FIDX_W-1:0]          frame_index,
  output logic                                evicted_valid,
  output logic [lru_pkg::PAGE_BITS-1:0]       evicted_page,
  output logic [lru_pkg::TOTAL_W-1:0]         hit_total,
  output logic [lru_pkg::TOTAL_W-1:0]         fault_total
);
  import lru_pkg::*;

  page_t              frame_page_r [FRAMES];
  frame_vec_t         frame_valid_r;
  age_t               frame_age_r  [FRAMES];
  logic [CFG_W-1:0]   cfg_r;
  page_t              page_r;
  total_t             hit_cnt_r;
  total_t             fault_cnt_r;

  logic               found_r;
  fidx_t              used_r;
  logic               ev_valid_r;
  page_t              ev_page_r;

  frame_vec_t         active;
  frame_vec_t         match;
  frame_vec_t         empty;
  frame_vec_t         cand;
  frame_vec_t         win;
  frame_vec_t         new_active;
  logic               found;
  logic               have_empty;
  fidx_t              hit_idx;
  fidx_t              empty_idx;
  fidx_t              oldest_idx;

  assign active = active_mask(active_count(cfg_r));
  assign new_active = active_mask(active_count(cfg_data));

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      cand[i]  = active[i] && frame_valid_r[i];
      match[i] = cand[i] && (frame_page_r[i] == page_r);
      empty[i] = active[i] && !frame_valid_r[i];
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      win[i] = cand[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (j < i && cand[j] && (frame_age_r[j] >= frame_age_r[i])) win[i] = 1'b0;
        if (j > i && cand[j] && (frame_age_r[j] > frame_age_r[i])) win[i] = 1'b0;
      end
    end
  end

  assign found      = |match;
  assign have_empty = |empty;
  assign hit_idx    = encode(lowest_set(match));
  assign empty_idx  = encode(lowest_set(empty));
  assign oldest_idx = encode(lowest_set(win));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r <= page_in;
    end
    if (cmd.lookup) begin
      found_r <= found;
      if (found) begin
        used_r     <= hit_idx;
        ev_valid_r <= 1'b0;
        ev_page_r  <= '0;
      end else if (have_empty) begin
        used_r     <= empty_idx;
        ev_valid_r <= 1'b0;
        ev_page_r  <= '0;
      end else begin
        used_r     <= oldest_idx;
        ev_valid_r <= 1'b1;
        ev_page_r  <= frame_page_r[oldest_idx];
      end
    end
    if (cmd.update && !found_r) begin
      frame_page_r[used_r] <= page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      cfg_r         <= CFG_W'(CFG_RESET);
      hit_cnt_r     <= '0;
      fault_cnt_r   <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        frame_age_r[i] <= '0;
      end
    end else if (cmd.cfg_write) begin
      cfg_r <= cfg_data;
      for (int i = 0; i < FRAMES; i++) begin
        if (!new_active[i]) begin
          frame_valid_r[i] <= 1'b0;
          frame_age_r[i]   <= '0;
        end
      end
    end else if (cmd.update) begin
      if (found_r) begin
        if (hit_cnt_r != '1) hit_cnt_r <= hit_cnt_r + total_t'(1);
      end else begin
        if (fault_cnt_r != '1) fault_cnt_r <= fault_cnt_r + total_t'(1);
        frame_valid_r[used_r] <= 1'b1;
      end
      for (int i = 0; i < FRAMES; i++) begin
        if (fidx_t'(i) == used_r) begin
          frame_age_r[i] <= '0;
        end else if (cand[i] && (int'(frame_age_r[i]) < AGE_MAX)) begin
          frame_age_r[i] <= frame_age_r[i] + age_t'(1);
        end
      end
    end
  end

  assign hit           = found_r;
  assign frame_index   = used_r;
  assign evicted_valid = ev_valid_r;
  assign evicted_page  = ev_page_r;
  assign hit_total     = hit_cnt_r;
  assign fault_total   = fault_cnt_r;

endmodule

`default_nettype wire

// File: rtl/lru_page_replacement.sv
// Each accepted request goes through LOOKUP, then UPDATE; out_valid is registered from UPDATE.
// LOOKUP searches the frame table, UPDATE writes it; a new request is taken in IDLE or UPDATE.
// The receiver cannot stall; out_valid is high for exactly one cycle per request.
// Synchronous active-low reset empties all frames, clears ages and counters.
// After reset all sixteen frames are in use; no clearing pass is needed.
`default_nettype none

module lru_page_replacement (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [lru_pkg::PAGE_BITS-1:0]  in_page_number,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lru_pkg::CFG_W-1:0]      cfg_frames_in_use,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [lru_pkg::FIDX_W-1:0]          out_frame_index,
  output logic                                out_evicted_valid,
  output logic [lru_pkg::PAGE_BITS-1:0]       out_evicted_page,
  output logic [lru_pkg::TOTAL_W-1:0]         out_hit_total,
  output logic [lru_pkg::TOTAL_W-1:0]         out_fault_total
);
  import lru_pkg::*;

  dp_cmd_t cmd;

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lru_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .page_in       (in_page_number),
    .cfg_data      (cfg_frames_in_use),
    .hit           (out_hit),
    .frame_index   (out_frame_index),
    .evicted_valid (out_evicted_valid),
    .evicted_page  (out_evicted_page),
    .hit_total     (out_hit_total),
    .fault_total   (out_fault_total)
  );

endmodule

`default_nettype wire
